@@ rtl/sdf_pkg.sv @@
// Shared widths and register indexes for the spring-damper force pipeline.
package sdf_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REST_LEN  = 2'd2;

  localparam int IN_FIELD_W = 32;
  localparam int IN_NFIELDS = 12;
  localparam int IN_DATA_W  = IN_FIELD_W * IN_NFIELDS;
  localparam int FORCE_W    = 48;
  localparam int OUT_DATA_W = 3 * FORCE_W;

  localparam int DIFF_W = 33;  // pb - pa, vb - va
  localparam int SQ_W   = 66;  // d.d and |vr.d|
  localparam int DIST_W = 33;
  localparam int VN_W   = 36;
  localparam int SM_W   = 53;  // |s|
  localparam int PN_W   = 86;  // |s * d_i|
  localparam int FQ_W   = 54;  // |s * d_i| / dist

endpackage

@@ rtl/sdf_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage.
module sdf_sqrt_pipe #(
  parameter int SW  = 66,
  parameter int SBW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SW-1:0]     in_rad,
  input  logic [SBW-1:0]    in_sb,
  output logic              out_valid,
  output logic [SW/2-1:0]   out_root,
  output logic [SBW-1:0]    out_sb
);

  localparam int IT = SW / 2;

  logic           stg_vld [IT+1];
  logic [SW-1:0]  stg_op  [IT+1];
  logic [SW-1:0]  stg_res [IT+1];
  logic [SBW-1:0] stg_sb  [IT+1];

  assign stg_vld[0] = in_valid;
  assign stg_op[0]  = in_rad;
  assign stg_res[0] = '0;
  assign stg_sb[0]  = in_sb;

  for (genvar s = 0; s < IT; s++) begin : g_stage
    localparam int E = SW - 2 - 2 * s;
    logic [SW-1:0] one_c, trial, op_nxt, res_nxt;

    assign one_c = {{(SW-1){1'b0}}, 1'b1} << E;
    assign trial = stg_res[s] + one_c;

    always_comb begin
      if (stg_op[s] >= trial) begin
        op_nxt  = stg_op[s] - trial;
        res_nxt = (stg_res[s] >> 1) + one_c;
      end else begin
        op_nxt  = stg_op[s];
        res_nxt = stg_res[s] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_vld[s+1] <= 1'b0;
      end else if (en) begin
        stg_vld[s+1] <= stg_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_op[s+1]  <= op_nxt;
        stg_res[s+1] <= res_nxt;
        stg_sb[s+1]  <= stg_sb[s];
      end
    end
  end

  assign out_valid = stg_vld[IT];
  assign out_root  = stg_res[IT][IT-1:0];
  assign out_sb    = stg_sb[IT];

endmodule

@@ rtl/sdf_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, lanes share the divisor.
module sdf_div_pipe #(
  parameter int NW  = 66,
  parameter int DW  = 33,
  parameter int QW  = 36,
  parameter int LN  = 1,
  parameter int SBW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [LN*NW-1:0]  in_num,
  input  logic [DW-1:0]     in_den,
  input  logic [SBW-1:0]    in_sb,
  output logic              out_valid,
  output logic [LN*QW-1:0]  out_quo,
  output logic [SBW-1:0]    out_sb
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic                   stg_vld [QW+1];
  logic [DW-1:0]          stg_den [QW+1];
  logic [SBW-1:0]         stg_sb  [QW+1];
  logic [LN-1:0][CW-1:0]  stg_rem [QW+1];
  logic [LN-1:0][QW-1:0]  stg_quo [QW+1];

  assign stg_vld[0] = in_valid;
  assign stg_den[0] = in_den;
  assign stg_sb[0]  = in_sb;
  for (genvar l = 0; l < LN; l++) begin : g_in
    assign stg_rem[0][l] = CW'(in_num[l*NW +: NW]);
    assign stg_quo[0][l] = '0;
    assign out_quo[l*QW +: QW] = stg_quo[QW][l];
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [CW-1:0]         dsh;
    logic [LN-1:0][CW-1:0] rem_nxt;
    logic [LN-1:0][QW-1:0] quo_nxt;

    assign dsh = CW'(stg_den[s]) << B;

    always_comb begin
      for (int l = 0; l < LN; l++) begin
        if (stg_rem[s][l] >= dsh) begin
          rem_nxt[l] = stg_rem[s][l] - dsh;
          quo_nxt[l] = {stg_quo[s][l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = stg_rem[s][l];
          quo_nxt[l] = {stg_quo[s][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_vld[s+1] <= 1'b0;
      end else if (en) begin
        stg_vld[s+1] <= stg_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_den[s+1] <= stg_den[s];
        stg_sb[s+1]  <= stg_sb[s];
        stg_rem[s+1] <= rem_nxt;
        stg_quo[s+1] <= quo_nxt;
      end
    end
  end

  assign out_valid = stg_vld[QW];
  assign out_sb    = stg_sb[QW];

endmodule

@@ rtl/spring_damper_force_top.sv @@
// Throughput: one word per cycle while the output is not stalled; set by the fully unrolled square root (33 stages)
// and the two restoring dividers (36 and 54 stages), each one bit per stage.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and the three coefficients.
// Coincident points give zero force with out_tuser set.
module spring_damper_force_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sdf_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [sdf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pa_x, pa_y, pa_z, pb_x, pb_y, pb_z, va_x, va_y, va_z, vb_x, vb_y, vb_z
  input  logic [sdf_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // force_x, force_y, force_z
  output logic [sdf_pkg::OUT_DATA_W-1:0]    out_tdata,
  // coincident
  output logic                              out_tuser
);

  import sdf_pkg::*;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // coefficients
  logic [31:0] k_r, c_r;
  logic [30:0] rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      c_r    <= '0;
      rest_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_STIFFNESS: k_r    <= cfg_wdata;
        REG_DAMPING:   c_r    <= cfg_wdata;
        REG_REST_LEN:  rest_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // ---- A: differences
  logic                     a_vld_r;
  logic signed [DIFF_W-1:0] a_d_r [3];
  logic signed [DIFF_W-1:0] a_vr_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_d_r[i]  <= $signed({in_tdata[32*(3+i)+31], in_tdata[32*(3+i) +: 32]})
                   - $signed({in_tdata[32*i+31], in_tdata[32*i +: 32]});
        a_vr_r[i] <= $signed({in_tdata[32*(9+i)+31], in_tdata[32*(9+i) +: 32]})
                   - $signed({in_tdata[32*(6+i)+31], in_tdata[32*(6+i) +: 32]});
      end
    end
  end

  // ---- B: products
  logic                     b_vld_r, b_coin_r;
  logic [SQ_W-1:0]          b_sq_r [3];
  logic signed [SQ_W-1:0]   b_dt_r [3];
  logic signed [DIFF_W-1:0] b_d_r [3];
  logic signed [SQ_W-1:0]   b_sq_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) b_sq_nxt[i] = a_d_r[i] * a_d_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (en) b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_coin_r <= (a_d_r[0] == '0) && (a_d_r[1] == '0) && (a_d_r[2] == '0);
      for (int i = 0; i < 3; i++) begin
        b_sq_r[i] <= $unsigned(b_sq_nxt[i]);
        b_dt_r[i] <= a_vr_r[i] * a_d_r[i];
        b_d_r[i]  <= a_d_r[i];
      end
    end
  end

  // ---- C: sums
  logic                     c_vld_r, c_coin_r;
  logic [SQ_W-1:0]          c_sq_r;
  logic signed [SQ_W:0]     c_dot_r;
  logic signed [DIFF_W-1:0] c_d_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (en) c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_coin_r <= b_coin_r;
      c_sq_r   <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      c_dot_r  <= $signed({b_dt_r[0][SQ_W-1], b_dt_r[0]})
                + $signed({b_dt_r[1][SQ_W-1], b_dt_r[1]})
                + $signed({b_dt_r[2][SQ_W-1], b_dt_r[2]});
      c_d_r    <= b_d_r;
    end
  end

  // ---- D: |dot|
  logic                     d_vld_r, d_coin_r, d_dneg_r;
  logic [SQ_W-1:0]          d_sq_r, d_dmag_r;
  logic signed [DIFF_W-1:0] d_d_r [3];
  logic [SQ_W:0]            d_dabs;

  assign d_dabs = c_dot_r[SQ_W] ? (~c_dot_r + 1'b1) : c_dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (en) d_vld_r <= c_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_coin_r <= c_coin_r;
      d_dneg_r <= c_dot_r[SQ_W];
      d_sq_r   <= c_sq_r;
      d_dmag_r <= d_dabs[SQ_W-1:0];
      d_d_r    <= c_d_r;
    end
  end

  // ---- square root
  localparam int SQ_SBW = 2 + SQ_W + 3 * DIFF_W;
  logic              sq_vld;
  logic [DIST_W-1:0] sq_dist;
  logic [SQ_SBW-1:0] sq_sb;

  sdf_sqrt_pipe #(.SW(SQ_W), .SBW(SQ_SBW)) u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (d_vld_r),
    .in_rad   (d_sq_r),
    .in_sb    ({d_coin_r, d_dneg_r, d_dmag_r, d_d_r[2], d_d_r[1], d_d_r[0]}),
    .out_valid(sq_vld),
    .out_root (sq_dist),
    .out_sb   (sq_sb)
  );

  // ---- vn = |dot| / dist
  localparam int VN_SBW = 2 + DIST_W + 3 * DIFF_W;
  logic              vn_vld;
  logic [VN_W-1:0]   vn_mag;
  logic [VN_SBW-1:0] vn_sb;

  sdf_div_pipe #(.NW(SQ_W), .DW(DIST_W), .QW(VN_W), .LN(1), .SBW(VN_SBW)) u_div_vn (
    .clk, .rst_n, .en,
    .in_valid (sq_vld),
    .in_num   (sq_sb[3*DIFF_W +: SQ_W]),
    .in_den   (sq_dist),
    .in_sb    ({sq_sb[SQ_SBW-1 -: 2], sq_dist, sq_sb[3*DIFF_W-1:0]}),
    .out_valid(vn_vld),
    .out_quo  (vn_mag),
    .out_sb   (vn_sb)
  );

  logic [DIST_W-1:0]        vn_dist;
  logic [3*DIFF_W-1:0]      vn_dvec;
  assign vn_dist = vn_sb[3*DIFF_W +: DIST_W];
  assign vn_dvec = vn_sb[3*DIFF_W-1:0];

  // ---- E: stretch
  logic                 e_vld_r, e_coin_r, e_stn_r, e_vnn_r;
  logic [DIST_W-1:0]    e_stm_r, e_dist_r;
  logic [VN_W-1:0]      e_vnm_r;
  logic [3*DIFF_W-1:0]  e_d_r;
  logic signed [DIST_W:0] e_st;

  assign e_st = $signed({1'b0, vn_dist}) - $signed({3'b0, rest_r});

  always_ff @(posedge clk) begin
    if (!rst_n) e_vld_r <= 1'b0;
    else if (en) e_vld_r <= vn_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_coin_r <= vn_sb[VN_SBW-1];
      e_vnn_r  <= vn_sb[VN_SBW-2];
      e_stn_r  <= e_st[DIST_W];
      e_stm_r  <= e_st[DIST_W] ? DIST_W'(-e_st) : e_st[DIST_W-1:0];
      e_vnm_r  <= vn_mag;
      e_dist_r <= vn_dist;
      e_d_r    <= vn_dvec;
    end
  end

  // ---- F: coefficient products
  logic                 f_vld_r, f_coin_r, f_stn_r, f_vnn_r;
  logic [64:0]          f_pk_r;
  logic [67:0]          f_pc_r;
  logic [DIST_W-1:0]    f_dist_r;
  logic [3*DIFF_W-1:0]  f_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else if (en) f_vld_r <= e_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_coin_r <= e_coin_r;
      f_stn_r  <= e_stn_r;
      f_vnn_r  <= e_vnn_r;
      f_pk_r   <= {33'b0, k_r} * {32'b0, e_stm_r};
      f_pc_r   <= {36'b0, c_r} * {32'b0, e_vnm_r};
      f_dist_r <= e_dist_r;
      f_d_r    <= e_d_r;
    end
  end

  // ---- G: s = T(k*stretch) + T(c*vn)
  logic                 g_vld_r, g_coin_r;
  logic [SM_W:0]        g_s_r;
  logic [DIST_W-1:0]    g_dist_r;
  logic [3*DIFF_W-1:0]  g_d_r;
  logic [SM_W:0]        g_tk, g_tc;

  assign g_tk = {5'b0, f_pk_r[64:16]};
  assign g_tc = {2'b0, f_pc_r[67:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) g_vld_r <= 1'b0;
    else if (en) g_vld_r <= f_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_coin_r <= f_coin_r;
      g_s_r    <= (f_stn_r ? -g_tk : g_tk) + (f_vnn_r ? -g_tc : g_tc);
      g_dist_r <= f_dist_r;
      g_d_r    <= f_d_r;
    end
  end

  // ---- H: magnitudes
  logic                 h_vld_r, h_coin_r, h_sn_r;
  logic [SM_W-1:0]      h_sm_r;
  logic [DIFF_W-1:0]    h_dm_r [3];
  logic [2:0]           h_dn_r;
  logic [DIST_W-1:0]    h_dist_r;
  logic [SM_W:0]        h_sneg;

  assign h_sneg = -g_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) h_vld_r <= 1'b0;
    else if (en) h_vld_r <= g_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_coin_r <= g_coin_r;
      h_sn_r   <= g_s_r[SM_W];
      h_sm_r   <= g_s_r[SM_W] ? h_sneg[SM_W-1:0] : g_s_r[SM_W-1:0];
      h_dist_r <= g_dist_r;
      for (int i = 0; i < 3; i++) begin
        h_dn_r[i] <= g_d_r[DIFF_W*i + DIFF_W-1];
        h_dm_r[i] <= g_d_r[DIFF_W*i + DIFF_W-1] ? -g_d_r[DIFF_W*i +: DIFF_W]
                                                : g_d_r[DIFF_W*i +: DIFF_W];
      end
    end
  end

  // ---- I: partial products of |s| * |d_i|, split at bit 27
  logic                 i_vld_r, i_coin_r;
  logic [59:0]          i_pl_r [3];
  logic [58:0]          i_ph_r [3];
  logic [2:0]           i_pn_r;
  logic [DIST_W-1:0]    i_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) i_vld_r <= 1'b0;
    else if (en) i_vld_r <= h_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_coin_r <= h_coin_r;
      i_dist_r <= h_dist_r;
      for (int i = 0; i < 3; i++) begin
        i_pl_r[i] <= {33'b0, h_sm_r[26:0]} * {27'b0, h_dm_r[i]};
        i_ph_r[i] <= {33'b0, h_sm_r[52:27]} * {26'b0, h_dm_r[i]};
        i_pn_r[i] <= h_sn_r ^ h_dn_r[i];
      end
    end
  end

  // ---- J: combine partials
  logic                 j_vld_r, j_coin_r;
  logic [3*PN_W-1:0]    j_num_r;
  logic [2:0]           j_pn_r;
  logic [DIST_W-1:0]    j_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) j_vld_r <= 1'b0;
    else if (en) j_vld_r <= i_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_coin_r <= i_coin_r;
      j_pn_r   <= i_pn_r;
      j_dist_r <= i_dist_r;
      for (int i = 0; i < 3; i++) begin
        j_num_r[PN_W*i +: PN_W] <= {26'b0, i_pl_r[i]} + {i_ph_r[i], 27'b0};
      end
    end
  end

  // ---- force components: |s*d_i| / dist
  logic              fd_vld;
  logic [3*FQ_W-1:0] fd_quo;
  logic [3:0]        fd_sb;

  sdf_div_pipe #(.NW(PN_W), .DW(DIST_W), .QW(FQ_W), .LN(3), .SBW(4)) u_div_f (
    .clk, .rst_n, .en,
    .in_valid (j_vld_r),
    .in_num   (j_num_r),
    .in_den   (j_dist_r),
    .in_sb    ({j_coin_r, j_pn_r}),
    .out_valid(fd_vld),
    .out_quo  (fd_quo),
    .out_sb   (fd_sb)
  );

  // ---- output: sign, saturate, coincident override
  localparam logic [FQ_W-1:0] POS_LIM = {{(FQ_W-FORCE_W+1){1'b0}}, {(FORCE_W-1){1'b1}}};
  localparam logic [FQ_W-1:0] NEG_LIM = POS_LIM + 1'b1;

  logic [OUT_DATA_W-1:0] out_nxt;
  logic                  out_tvalid_r, out_tuser_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  always_comb begin
    logic [FQ_W-1:0]    q, m;
    logic [FORCE_W-1:0] f;
    for (int i = 0; i < 3; i++) begin
      q = fd_quo[FQ_W*i +: FQ_W];
      // force = -(s*d)/dist: a positive product gives a negative force
      if (!fd_sb[i]) begin
        m = (q > NEG_LIM) ? NEG_LIM : q;
        f = -m[FORCE_W-1:0];
      end else begin
        m = (q > POS_LIM) ? POS_LIM : q;
        f = m[FORCE_W-1:0];
      end
      out_nxt[FORCE_W*i +: FORCE_W] = fd_sb[3] ? '0 : f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (en) out_tvalid_r <= fd_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_nxt;
      out_tuser_r <= fd_sb[3];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---- checks
  a_coin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("coincident word carries nonzero force");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(a_vld_r) && $stable(j_vld_r))
    else $error("pipeline moved during output stall");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid_r && !a_vld_r)
    else $error("valid bits not cleared by reset");

endmodule
